>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define PFPE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define PFPE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/pfpe_pkg.sv
`timescale 1ns / 1ps

package pfpe_pkg;

    localparam int COLUMNS     = 64;
    localparam int ROWS        = 32;
    localparam int PAGES       = (ROWS + 7) / 8;
    localparam int STORE_BYTES = COLUMNS * PAGES;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int COL_W       = $clog2(COLUMNS);

    // Job counts of the whole-store sweeps (pairs or single bytes).
    localparam int COL_JOBS  = PAGES * (COLUMNS / 2);
    localparam int ROW_PAIRS = (PAGES / 2) * COLUMNS;
    localparam int BOTH_JOBS = STORE_BYTES / 2;
    localparam int ROWS_MID  = PAGES % 2;
    localparam int BOTH_MID  = STORE_BYTES % 2;

    typedef enum logic [3:0] {
        REQ_SET        = 4'd0,
        REQ_CLEAR      = 4'd1,
        REQ_INVERT     = 4'd2,
        REQ_CLEAR_ALL  = 4'd3,
        REQ_INVERT_ALL = 4'd4,
        REQ_MIRROR_COL = 4'd5,
        REQ_MIRROR_ROW = 4'd6,
        REQ_MIRROR_ALL = 4'd7,
        REQ_READ       = 4'd8
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WORK,
        ST_RD_A,
        ST_RD_B,
        ST_WR_A,
        ST_WR_B
    } state_t;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_PIXEL,
        KIND_READ,
        KIND_CLEAR
    } kind_t;

    typedef enum logic [1:0] {
        SW_INVERT,
        SW_COLS,
        SW_ROWS,
        SW_BOTH
    } sweep_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              clear_all;
    } store_req_t;

    function automatic logic [7:0] flip_bits(input logic [7:0] b);
        logic [7:0] r;
        for (int k = 0; k < 8; k++)
        begin
            r[7-k] = b[k];
        end
        return r;
    endfunction

endpackage

>>> rtl/pfpe_store.sv
`timescale 1ns / 1ps

// Pixel byte store: one read port with registered data, one write port.
// Valid bits give the blank value for entries not written since the last clear.
module pfpe_store (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pfpe_pkg::store_req_t   req,
    output logic [7:0]             rdata
);

    logic [7:0]                       mem [pfpe_pkg::STORE_BYTES];
    logic [7:0]                       q_reg;
    logic                             vq_reg;
    logic [pfpe_pkg::STORE_BYTES-1:0] valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            q_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            vq_reg    <= 1'b0;
        end
        else
        begin
            if (req.clear_all)
            begin
                valid_reg <= '0;
            end
            else if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                vq_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rdata = vq_reg ? q_reg : 8'd0;

endmodule

>>> rtl/page_framebuffer_pixel_engine.sv
`timescale 1ns / 1ps

// Page-organized monochrome framebuffer. Each store byte holds eight vertical
// pixels of one column; byte page * COLUMNS + x carries rows page * 8 .. +7.
// Requests enter on the s_ stream: s_tuser is the request code, s_tdata the
// column, row and byte index. Every request produces exactly one result beat
// on the m_ stream: m_tuser is the status flag and m_tdata the byte read.
// Pixel set, clear and invert, single-byte reads, whole-store clears and
// rejected requests read the store in the accept cycle; the read-modify-write
// completes in the work state once the output register is free, and the
// result is registered there. The block takes one request at a time and
// accepts no new one until the last result is registered. Invert-all walks
// the store one byte at a time with a read and a write per byte; the three
// mirror requests swap byte pairs with two reads and two writes each, and a
// middle byte takes one read and one write. That serial walk comes from the
// single read port and single write port of the byte store.
// Reset clears the valid bits of the store at once, so the display reads blank
// right after reset without a clearing pass. A stalled result holds in the
// output register; the block may still accept the next request, and then waits
// in its work state, with s_tready low, until m_tready takes the beat.
module page_framebuffer_pixel_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // x_coord [7:0], y_coord [15:8], byte_index [23:16]
    input  logic [3:0]  s_tuser,   // req_type [3:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // read_byte [7:0]
    output logic        m_tuser    // status [0]
);

    localparam int AW = pfpe_pkg::ADDR_W;
    localparam int CW = pfpe_pkg::COL_W;
    localparam int C  = pfpe_pkg::COLUMNS;

    pfpe_pkg::state_t     state_reg, state_next;
    pfpe_pkg::kind_t      kind_reg, kind_next;
    pfpe_pkg::sweep_t     sw_reg, sw_next;
    pfpe_pkg::req_t       op_reg, op_next;
    logic                 status_reg, status_next;
    logic [2:0]           bit_reg, bit_next;
    logic [AW-1:0]        a_reg, a_next;
    logic [AW-1:0]        b_reg, b_next;
    logic [AW-1:0]        cnt_reg, cnt_next;
    logic [CW-1:0]        col_reg, col_next;
    logic                 single_reg, single_next;
    logic [7:0]           hold_reg, hold_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [7:0]           m_tdata_reg, m_tdata_next;
    logic                 m_tuser_reg, m_tuser_next;

    pfpe_pkg::store_req_t store_req;
    logic [7:0]           rdata;

    logic [7:0]           x_coord;
    logic [7:0]           y_coord;
    logic [7:0]           byte_index;
    logic [AW-1:0]        pix_addr;
    logic                 pix_ok;
    logic                 idx_ok;
    logic                 accept;
    logic                 out_free;
    logic                 sweep_in;
    logic                 job_end;
    logic                 mid_exists;
    logic                 enter_mid;
    logic                 sweep_done;
    logic [7:0]           pix_mask;
    logic [7:0]           pix_data;

    assign x_coord    = s_tdata[7:0];
    assign y_coord    = s_tdata[15:8];
    assign byte_index = s_tdata[23:16];

    assign pix_addr = AW'(x_coord) + AW'(int'(y_coord >> 3) * C);
    assign pix_ok   = (16'(x_coord) < 16'(pfpe_pkg::COLUMNS))
                   && (16'(y_coord) < 16'(pfpe_pkg::ROWS));
    assign idx_ok   = 16'(byte_index) < 16'(pfpe_pkg::STORE_BYTES);

    assign accept   = s_tvalid && (state_reg == pfpe_pkg::ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;
    assign sweep_in = (s_tuser == pfpe_pkg::REQ_INVERT_ALL)
                   || (s_tuser == pfpe_pkg::REQ_MIRROR_COL)
                   || (s_tuser == pfpe_pkg::REQ_MIRROR_ROW)
                   || (s_tuser == pfpe_pkg::REQ_MIRROR_ALL);

    // A sweep job ends after its last write; a row or full mirror over an odd
    // span finishes with a run of single bytes that are only bit-reversed.
    assign job_end    = ((state_reg == pfpe_pkg::ST_WR_A) && single_reg)
                     || (state_reg == pfpe_pkg::ST_WR_B);
    assign mid_exists = ((sw_reg == pfpe_pkg::SW_ROWS) && (pfpe_pkg::ROWS_MID == 1))
                     || ((sw_reg == pfpe_pkg::SW_BOTH) && (pfpe_pkg::BOTH_MID == 1));
    assign enter_mid  = !single_reg && mid_exists;
    assign sweep_done = (cnt_reg == '0) && !enter_mid;

    assign pix_mask = 8'd1 << bit_reg;

    always_comb
    begin
        unique case (op_reg)
            pfpe_pkg::REQ_SET:    pix_data = rdata | pix_mask;
            pfpe_pkg::REQ_CLEAR:  pix_data = rdata & ~pix_mask;
            default:              pix_data = rdata ^ pix_mask;
        endcase
    end

    function automatic logic [7:0] sweep_xform(input pfpe_pkg::sweep_t sw,
                                               input logic [7:0] d);
        logic [7:0] r;
        unique case (sw)
            pfpe_pkg::SW_INVERT: r = ~d;
            pfpe_pkg::SW_COLS:   r = d;
            default:             r = pfpe_pkg::flip_bits(d);
        endcase
        return r;
    endfunction

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pfpe_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = sweep_in ? pfpe_pkg::ST_RD_A : pfpe_pkg::ST_WORK;
                end
            end
            pfpe_pkg::ST_WORK:
            begin
                if (out_free)
                begin
                    state_next = pfpe_pkg::ST_IDLE;
                end
            end
            pfpe_pkg::ST_RD_A:
            begin
                state_next = single_reg ? pfpe_pkg::ST_WR_A : pfpe_pkg::ST_RD_B;
            end
            pfpe_pkg::ST_RD_B:
            begin
                state_next = pfpe_pkg::ST_WR_A;
            end
            pfpe_pkg::ST_WR_A,
            pfpe_pkg::ST_WR_B:
            begin
                if (job_end)
                begin
                    state_next = sweep_done ? pfpe_pkg::ST_WORK : pfpe_pkg::ST_RD_A;
                end
                else
                begin
                    state_next = pfpe_pkg::ST_WR_B;
                end
            end
            default:
            begin
                state_next = pfpe_pkg::ST_IDLE;
            end
        endcase
    end

    // Store port and handshake outputs.
    always_comb
    begin
        store_req = '0;
        s_tready  = 1'b0;
        unique case (state_reg)
            pfpe_pkg::ST_IDLE:
            begin
                s_tready          = 1'b1;
                store_req.rd_en   = s_tvalid;
                store_req.rd_addr = (s_tuser == pfpe_pkg::REQ_READ) ? AW'(byte_index)
                                                                    : pix_addr;
            end
            pfpe_pkg::ST_WORK:
            begin
                store_req.wr_en     = out_free && (kind_reg == pfpe_pkg::KIND_PIXEL);
                store_req.wr_addr   = a_reg;
                store_req.wr_data   = pix_data;
                store_req.clear_all = out_free && (kind_reg == pfpe_pkg::KIND_CLEAR);
            end
            pfpe_pkg::ST_RD_A:
            begin
                store_req.rd_en   = 1'b1;
                store_req.rd_addr = a_reg;
            end
            pfpe_pkg::ST_RD_B:
            begin
                store_req.rd_en   = 1'b1;
                store_req.rd_addr = b_reg;
            end
            pfpe_pkg::ST_WR_A:
            begin
                store_req.wr_en   = 1'b1;
                store_req.wr_addr = a_reg;
                store_req.wr_data = sweep_xform(sw_reg, rdata);
            end
            pfpe_pkg::ST_WR_B:
            begin
                store_req.wr_en   = 1'b1;
                store_req.wr_addr = b_reg;
                store_req.wr_data = sweep_xform(sw_reg, hold_reg);
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Request decode, sweep address walk and result register.
    always_comb
    begin
        kind_next     = kind_reg;
        sw_next       = sw_reg;
        op_next       = op_reg;
        status_next   = status_reg;
        bit_next      = bit_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        cnt_next      = cnt_reg;
        col_next      = col_reg;
        single_next   = single_reg;
        hold_next     = hold_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        if (accept)
        begin
            op_next     = pfpe_pkg::req_t'(s_tuser);
            bit_next    = y_coord[2:0];
            a_next      = pix_addr;
            kind_next   = pfpe_pkg::KIND_NONE;
            status_next = 1'b0;
            col_next    = '0;
            unique case (s_tuser)
                pfpe_pkg::REQ_SET,
                pfpe_pkg::REQ_CLEAR,
                pfpe_pkg::REQ_INVERT:
                begin
                    kind_next   = pix_ok ? pfpe_pkg::KIND_PIXEL : pfpe_pkg::KIND_NONE;
                    status_next = !pix_ok;
                end
                pfpe_pkg::REQ_CLEAR_ALL:
                begin
                    kind_next = pfpe_pkg::KIND_CLEAR;
                end
                pfpe_pkg::REQ_INVERT_ALL:
                begin
                    sw_next     = pfpe_pkg::SW_INVERT;
                    a_next      = '0;
                    single_next = 1'b1;
                    cnt_next    = AW'(pfpe_pkg::STORE_BYTES - 1);
                end
                pfpe_pkg::REQ_MIRROR_COL:
                begin
                    sw_next     = pfpe_pkg::SW_COLS;
                    a_next      = '0;
                    b_next      = AW'(C - 1);
                    single_next = 1'b0;
                    cnt_next    = AW'(pfpe_pkg::COL_JOBS - 1);
                end
                pfpe_pkg::REQ_MIRROR_ROW:
                begin
                    sw_next = pfpe_pkg::SW_ROWS;
                    a_next  = '0;
                    b_next  = AW'((pfpe_pkg::PAGES - 1) * C);
                    if (pfpe_pkg::ROW_PAIRS > 0)
                    begin
                        single_next = 1'b0;
                        cnt_next    = AW'(pfpe_pkg::ROW_PAIRS - 1);
                    end
                    else
                    begin
                        single_next = 1'b1;
                        cnt_next    = AW'(C - 1);
                    end
                end
                pfpe_pkg::REQ_MIRROR_ALL:
                begin
                    sw_next     = pfpe_pkg::SW_BOTH;
                    a_next      = '0;
                    b_next      = AW'(pfpe_pkg::STORE_BYTES - 1);
                    single_next = 1'b0;
                    cnt_next    = AW'(pfpe_pkg::BOTH_JOBS - 1);
                end
                pfpe_pkg::REQ_READ:
                begin
                    kind_next   = idx_ok ? pfpe_pkg::KIND_READ : pfpe_pkg::KIND_NONE;
                    status_next = !idx_ok;
                end
                default:
                begin
                    status_next = 1'b1;
                end
            endcase
        end

        if (state_reg == pfpe_pkg::ST_RD_B)
        begin
            hold_next = rdata;
        end

        if (job_end)
        begin
            if (cnt_reg == '0)
            begin
                if (enter_mid)
                begin
                    single_next = 1'b1;
                    a_next      = a_reg + 1'b1;
                    cnt_next    = (sw_reg == pfpe_pkg::SW_ROWS) ? AW'(C - 1) : '0;
                end
                else
                begin
                    kind_next = pfpe_pkg::KIND_NONE;
                end
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
                if (single_reg)
                begin
                    a_next = a_reg + 1'b1;
                end
                else
                begin
                    unique case (sw_reg)
                        pfpe_pkg::SW_COLS:
                        begin
                            // Next page starts at its outer column pair; with an
                            // odd column count the middle column is skipped.
                            if (col_reg == CW'(C / 2 - 1))
                            begin
                                col_next = '0;
                                a_next   = a_reg + AW'(C - C / 2 + 1);
                                b_next   = b_reg + AW'(C + C / 2 - 1);
                            end
                            else
                            begin
                                col_next = col_reg + 1'b1;
                                a_next   = a_reg + 1'b1;
                                b_next   = b_reg - 1'b1;
                            end
                        end
                        pfpe_pkg::SW_ROWS:
                        begin
                            // The partner page moves one page up at each wrap.
                            if (col_reg == CW'(C - 1))
                            begin
                                col_next = '0;
                                a_next   = a_reg + 1'b1;
                                b_next   = b_reg - AW'(2 * C - 1);
                            end
                            else
                            begin
                                col_next = col_reg + 1'b1;
                                a_next   = a_reg + 1'b1;
                                b_next   = b_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                            a_next = a_reg + 1'b1;
                            b_next = b_reg - 1'b1;
                        end
                    endcase
                end
            end
        end

        if ((state_reg == pfpe_pkg::ST_WORK) && out_free)
        begin
            m_tvalid_next = 1'b1;
            m_tuser_next  = status_reg;
            m_tdata_next  = (kind_reg == pfpe_pkg::KIND_READ) ? rdata : 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= pfpe_pkg::ST_IDLE;
            kind_reg     <= pfpe_pkg::KIND_NONE;
            sw_reg       <= pfpe_pkg::SW_INVERT;
            single_reg   <= 1'b0;
            cnt_reg      <= '0;
            col_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            kind_reg     <= kind_next;
            sw_reg       <= sw_next;
            single_reg   <= single_next;
            cnt_reg      <= cnt_next;
            col_reg      <= col_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        status_reg  <= status_next;
        bit_reg     <= bit_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        hold_reg    <= hold_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    pfpe_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (store_req),
        .rdata (rdata)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

>>> rtl/pfpe_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Port-level checks of the framebuffer engine.
module pfpe_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser
);

    `PFPE_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "result beat dropped while stalled")
    `PFPE_ASSERT(a_out_stable, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
    `PFPE_ASSERT(a_bad_zero, m_tvalid && m_tuser |-> m_tdata == 8'd0, "rejected request carries data")
    `PFPE_ASSERT(a_one_at_a_time, s_tvalid && s_tready |=> !s_tready, "second request taken before the first finished")
    `PFPE_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !m_tvalid, "result valid during reset")

endmodule

bind page_framebuffer_pixel_engine pfpe_checker u_checker (.*);

>>> tb/tb_page_framebuffer_pixel_engine.sv
`timescale 1ns / 1ps

module tb_page_framebuffer_pixel_engine;

    import pfpe_pkg::*;

    // Request codes above REQ_READ are not defined and must be rejected.
    localparam logic [3:0] REQ_BAD_FIRST = 4'd9;
    localparam logic [3:0] REQ_BAD_LAST  = 4'd15;

    // A sweep over the whole store runs with no beat moving, and the receiver
    // may stall on top of that. STALL_LIMIT leaves a wide margin over both.
    localparam int STALL_LIMIT   = 4000;
    localparam int RANDOM_ITEMS  = 925;
    localparam int DIRECTED_ROWS = 25;
    localparam int SETTLE_CYCLES = 20;

    // One result beat as the block reports it.
    typedef struct packed {
        logic       status;
        logic [7:0] read_byte;
    } reply_t;

    // One row of the directed table. Where typed is set, the expected reply is
    // the one written in the row; otherwise the shadow store predicts it.
    typedef struct packed {
        logic [3:0] code;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] idx;
        logic       typed;
        logic       want_status;
        logic [7:0] want_byte;
    } drive_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // x_coord [7:0], y_coord [15:8], byte_index [23:16]
    logic [3:0]  s_tuser;   // req_type [3:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // read_byte [7:0]
    logic        m_tuser;   // status [0]

    // Shadow copy of the pixel store and the replies still owed by the block.
    logic [7:0] shadow_fb [STORE_BYTES];
    reply_t     pending_replies [$];

    int err_count   = 0;
    int idle_cycles = 0;
    bit sender_calm = 1'b0;

    // Directed part: blank store after reset, the corners of the pixel space,
    // out-of-bounds pixels, every whole-store request with a read-back after
    // it, and the lowest and highest undefined request codes.
    drive_row_t directed_rows [DIRECTED_ROWS] = '{
        '{REQ_READ,       8'd0,           8'd0,        8'd0,
          1'b1, 1'b0, 8'h00},
        '{REQ_READ,       8'hFF,          8'hFF,       8'(STORE_BYTES - 1),
          1'b1, 1'b0, 8'h00},
        '{REQ_SET,        8'd0,           8'd0,        8'd0,
          1'b0, 1'b0, 8'h00},
        '{REQ_SET,        8'(COLUMNS - 1), 8'(ROWS - 1), 8'd0,
          1'b0, 1'b0, 8'h00},
        '{REQ_SET,        8'd5,           8'd7,        8'd0,
          1'b0, 1'b0, 8'h00},
        '{REQ_READ,       8'd0,           8'd0,        8'd0,
          1'b0, 1'b0, 8'h00},
        '{REQ_READ,       8'd0,           8'd0,        8'(STORE_BYTES - 1),
          1'b0, 1'b0, 8'h00},
        '{REQ_SET,        8'(COLUMNS),    8'd0,        8'd0,
          1'b1, 1'b1, 8'h00},
        '{REQ_CLEAR,      8'd0,           8'(ROWS),    8'd0,
          1'b1, 1'b1, 8'h00},
        '{REQ_INVERT,     8'hFF,          8'hFF,       8'hFF,
          1'b1, 1'b1, 8'h00},
        '{REQ_INVERT,     8'd3,           8'd10,       8'd0,
          1'b0, 1'b0, 8'h00},
        '{REQ_CLEAR,      8'd0,           8'd0,        8'd0,
          1'b0, 1'b0, 8'h00},
        '{REQ_READ,       8'd0,           8'd0,        8'(COLUMNS + 3),
          1'b0, 1'b0, 8'h00},
        '{REQ_MIRROR_COL, 8'd0,           8'd0,        8'd0,
          1'b0, 1'b0, 8'h00},
        '{REQ_READ,       8'd0,           8'd0,        8'(COLUMNS - 1),
          1'b0, 1'b0, 8'h00},
        '{REQ_MIRROR_ROW, 8'd0,           8'd0,        8'd0,
          1'b0, 1'b0, 8'h00},
        '{REQ_READ,       8'd0,           8'd0,        8'(STORE_BYTES - 1),
          1'b0, 1'b0, 8'h00},
        '{REQ_MIRROR_ALL, 8'd0,           8'd0,        8'd0,
          1'b0, 1'b0, 8'h00},
        '{REQ_READ,       8'd0,           8'd0,        8'd0,
          1'b0, 1'b0, 8'h00},
        '{REQ_INVERT_ALL, 8'd0,           8'd0,        8'd0,
          1'b0, 1'b0, 8'h00},
        '{REQ_READ,       8'd0,           8'd0,        8'd5,
          1'b0, 1'b0, 8'h00},
        '{REQ_CLEAR_ALL,  8'd0,           8'd0,        8'd0,
          1'b0, 1'b0, 8'h00},
        '{REQ_READ,       8'hFF,          8'hFF,       8'(STORE_BYTES - 1),
          1'b1, 1'b0, 8'h00},
        '{REQ_BAD_FIRST,  8'd0,           8'd0,        8'd0,
          1'b1, 1'b1, 8'h00},
        '{REQ_BAD_LAST,   8'hFF,          8'hFF,       8'hFF,
          1'b1, 1'b1, 8'h00}
    };

    page_framebuffer_pixel_engine dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Idle length for either side. In a calm stretch there is no idling at
    // all; otherwise most gaps are short and a few are long.
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Bit order of a byte flipped, so that row k of a page becomes row 7 - k.
    function automatic logic [7:0] bits_reversed(input logic [7:0] b);
        logic [7:0] r;
        for (int k = 0; k < 8; k++)
        begin
            r[k] = b[7 - k];
        end
        return r;
    endfunction

    // Applies one request to the shadow store and returns the reply that the
    // block owes for it. Sweeps read from a snapshot taken before the request,
    // so each destination byte is simply a function of one source byte.
    task automatic apply_framebuffer_request(input logic [3:0] code,
                                             input logic [7:0] x,
                                             input logic [7:0] y,
                                             input logic [7:0] idx,
                                             output reply_t rep);
        logic [7:0] snap [STORE_BYTES];
        logic [7:0] mask;
        int         a;
        rep  = '0;
        snap = shadow_fb;
        case (code)
            REQ_SET, REQ_CLEAR, REQ_INVERT:
            begin
                if (x >= COLUMNS || y >= ROWS)
                begin
                    rep.status = 1'b1;
                end
                else
                begin
                    a    = int'(x) + (int'(y) / 8) * COLUMNS;
                    mask = 8'd1 << y[2:0];
                    if (code == REQ_SET)
                        shadow_fb[a] = shadow_fb[a] | mask;
                    else if (code == REQ_CLEAR)
                        shadow_fb[a] = shadow_fb[a] & ~mask;
                    else
                        shadow_fb[a] = shadow_fb[a] ^ mask;
                end
            end
            REQ_CLEAR_ALL:
            begin
                foreach (shadow_fb[i])
                    shadow_fb[i] = 8'h00;
            end
            REQ_INVERT_ALL:
            begin
                foreach (shadow_fb[i])
                    shadow_fb[i] = ~snap[i];
            end
            REQ_MIRROR_COL:
            begin
                for (int p = 0; p < PAGES; p++)
                    for (int c = 0; c < COLUMNS; c++)
                        shadow_fb[p * COLUMNS + c] = snap[p * COLUMNS + COLUMNS - 1 - c];
            end
            REQ_MIRROR_ROW:
            begin
                // Pages trade places and every byte is flipped; with an odd
                // page count the middle page maps onto itself.
                for (int p = 0; p < PAGES; p++)
                    for (int c = 0; c < COLUMNS; c++)
                        shadow_fb[p * COLUMNS + c] =
                            bits_reversed(snap[(PAGES - 1 - p) * COLUMNS + c]);
            end
            REQ_MIRROR_ALL:
            begin
                foreach (shadow_fb[i])
                    shadow_fb[i] = bits_reversed(snap[STORE_BYTES - 1 - i]);
            end
            REQ_READ:
            begin
                if (idx >= STORE_BYTES)
                    rep.status = 1'b1;
                else
                    rep.read_byte = shadow_fb[idx];
            end
            default:
            begin
                rep.status = 1'b1;
            end
        endcase
    endtask

    // Offers one request after a random gap and records its reply once the
    // beat is taken. tvalid stays high after the beat, so a back-to-back
    // request only changes the data at the next falling edge.
    task automatic send_request(input logic [3:0] code, input logic [7:0] x,
                                input logic [7:0] y, input logic [7:0] idx,
                                input logic typed, input reply_t want);
        reply_t predicted;
        int     gap;
        if ($urandom_range(0, 99) < 4)
            sender_calm = !sender_calm;
        gap = pick_gap(sender_calm);
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= code;
        s_tdata  <= {idx, y, x};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        apply_framebuffer_request(code, x, y, idx, predicted);
        pending_replies.push_back(typed ? want : predicted);
    endtask

    // Takes the request stream down and holds until every reply is back.
    task automatic drain_replies();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: ready is changed only at falling edges. Stalls of random
    // length alternate with calm stretches where every beat is taken at once.
    initial
    begin
        int stall;
        bit calm;
        stall    = 0;
        calm     = 1'b0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 99) < 4)
                    calm = !calm;
                stall = pick_gap(calm);
            end
        end
    end

    // Reply checker and watchdog. Each result beat is matched against the
    // oldest reply still owed; the watchdog ends the run when no beat moves
    // on either side until the idle counter reaches STALL_LIMIT.
    always @(posedge clk)
    begin
        reply_t want;
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_replies.size() == 0)
                begin
                    $display("%0t: result beat with no reply owed: status %0b byte %02h",
                             $time, m_tuser, m_tdata);
                    err_count++;
                end
                else
                begin
                    want = pending_replies.pop_front();
                    if (m_tuser !== want.status)
                    begin
                        $display("%0t: status mismatch: expected %0b, got %0b",
                                 $time, want.status, m_tuser);
                        err_count++;
                    end
                    if (m_tdata !== want.read_byte)
                    begin
                        $display("%0t: read_byte mismatch: expected %02h, got %02h",
                                 $time, want.read_byte, m_tdata);
                        err_count++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles + 1 >= STALL_LIMIT)
            begin
                $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
                $display("tb_page_framebuffer_pixel_engine: done, errors");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Main sequence: reset, directed table, random requests, drain, verdict.
    initial
    begin
        logic [3:0] code;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] idx;
        int         r;
        int         last_addr;
        drive_row_t row;

        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        last_addr = 0;
        foreach (shadow_fb[i])
            shadow_fb[i] = 8'h00;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            send_request(row.code, row.x, row.y, row.idx, row.typed,
                         {row.want_status, row.want_byte});
        end

        // Let the block run dry once before the random part.
        drain_replies();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // Fields that a request does not use still carry random noise.
            x   = 8'($urandom);
            y   = 8'($urandom);
            idx = 8'($urandom);
            r   = $urandom_range(0, 99);
            if (r < 30)
            begin
                // In-bounds pixel edit; its byte is remembered for read-back.
                code      = 4'($urandom_range(REQ_INVERT, REQ_SET));
                x         = 8'($urandom_range(COLUMNS - 1, 0));
                y         = 8'($urandom_range(ROWS - 1, 0));
                last_addr = int'(x) + (int'(y) / 8) * COLUMNS;
            end
            else if (r < 38)
            begin
                // Pixel edit over the full coordinate range, mostly rejected.
                code = 4'($urandom_range(REQ_INVERT, REQ_SET));
            end
            else if (r < 70)
            begin
                code = REQ_READ;
                idx  = 8'(last_addr);
            end
            else if (r < 84)
            begin
                code = REQ_READ;
            end
            else if (r < 95)
            begin
                code = 4'($urandom_range(REQ_MIRROR_ALL, REQ_CLEAR_ALL));
            end
            else
            begin
                code = 4'($urandom_range(REQ_BAD_LAST, REQ_BAD_FIRST));
            end
            send_request(code, x, y, idx, 1'b0, '0);
            if ($urandom_range(0, 199) == 0)
                drain_replies();
        end

        drain_replies();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("tb_page_framebuffer_pixel_engine: done, clean");
        else
            $display("tb_page_framebuffer_pixel_engine: done, errors");
        $finish;
    end

endmodule
